### src/tshp_pkg.sv
// Package for the task set hyperperiod prefix unit.
// Shared widths, sequencer states and divider control types. No dependencies.
package tshp_pkg;

  localparam int unsigned PeriodW = 31;
  localparam int unsigned OffsetW = 31;
  localparam int unsigned UtilW   = 17;
  localparam int unsigned HypW    = 63;
  localparam int unsigned StableW = 33;
  localparam int unsigned SumW    = 24;
  localparam int unsigned DivW    = 64;
  localparam int unsigned CntW    = 7;

  localparam logic [HypW-1:0] HypMax = {HypW{1'b1}};
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_QUOT,
    ST_CHECK,
    ST_CEIL,
    ST_FINISH,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
    logic [DivW-1:0] rem;
  } div_rsp_t;

endpackage

### src/tshp_if.sv
// Valid/ready channel interface carrying one packed payload word.
// Depends on nothing; the payload width is set per instance.
interface tshp_if #(
  parameter int unsigned Width = 8
) (
  input logic clk
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/task_set_hyperperiod_prefix_unit.sv
// Task set hyperperiod prefix unit: one result word per task word.
// The first task of a set goes through the finish state straight to the output.
// Later tasks chain divides on the shared one-bit-per-cycle divider: one per
// gcd remainder step, one more that closes the gcd, then lcm/gcd, the overflow
// bound and the ceiling.
// One task at a time, next accepted in the cycle after the result leaves.
// Synchronous active-low reset clears the sequencer state and the started flag.
module task_set_hyperperiod_prefix_unit (
  input logic clk,
  input logic rst_n,
  tshp_if.sink   in_ch,
  tshp_if.source out_ch
);
  import tshp_pkg::*;

  logic [PeriodW-1:0]  period;
  logic [OffsetW-1:0]  release_offset;
  logic [UtilW-1:0]    utilization;
  logic                last_task;
  logic [HypW-1:0]     hyperperiod;
  logic                lcm_overflow;
  logic [OffsetW-1:0]  min_offset, max_offset;
  logic [StableW-1:0]  task_stable_time, set_stable_time;
  logic [SumW-1:0]     util_sum;
  logic                set_done;

  // Unpack task word
  assign {period, release_offset, utilization, last_task} = in_ch.data;

  tshp_seq u_seq (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .period(period), .release_offset(release_offset),
    .utilization(utilization), .last_task(last_task),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .hyperperiod(hyperperiod), .lcm_overflow(lcm_overflow),
    .min_offset(min_offset), .max_offset(max_offset),
    .task_stable_time(task_stable_time), .set_stable_time(set_stable_time),
    .util_sum(util_sum), .set_done(set_done)
  );

  // Pack result word
  assign out_ch.data = {hyperperiod, lcm_overflow, min_offset, max_offset,
                        task_stable_time, set_stable_time, util_sum, set_done};
endmodule

### src/tshp_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on tshp_pkg for request and response types.
module tshp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  tshp_pkg::div_req_t req,
  output tshp_pkg::div_rsp_t rsp
);
  import tshp_pkg::*;

  logic [DivW-1:0] quot_r, quot_nxt;
  logic [DivW-1:0] rem_r, rem_nxt;
  logic [DivW-1:0] dvs_r, dvs_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DivW:0]   trial;
  logic [DivW:0]   shifted;

  // Shift in next dividend bit, subtract if it fits
  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quot_r[DivW-1]};
    trial    = shifted - {1'b0, dvs_r};
    if (req.start) begin
      quot_nxt = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DivW]) begin
        rem_nxt = trial[DivW-1:0];
      end else begin
        rem_nxt = shifted[DivW-1:0];
      end
      quot_nxt = {quot_r[DivW-2:0], ~trial[DivW]};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CntW'(DivW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;
endmodule

### src/tshp_seq.sv
// Sequencer: runs gcd, quotient, overflow check and ceiling on the divider.
// Depends on tshp_pkg and tshp_div.
module tshp_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tshp_pkg::PeriodW-1:0]   period,
  input  logic [tshp_pkg::OffsetW-1:0]   release_offset,
  input  logic [tshp_pkg::UtilW-1:0]     utilization,
  input  logic                           last_task,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tshp_pkg::HypW-1:0]      hyperperiod,
  output logic                           lcm_overflow,
  output logic [tshp_pkg::OffsetW-1:0]   min_offset,
  output logic [tshp_pkg::OffsetW-1:0]   max_offset,
  output logic [tshp_pkg::StableW-1:0]   task_stable_time,
  output logic [tshp_pkg::StableW-1:0]   set_stable_time,
  output logic [tshp_pkg::SumW-1:0]      util_sum,
  output logic                           set_done
);
  import tshp_pkg::*;

  seq_state_t state_r, state_nxt;
  div_req_t   req;
  div_rsp_t   rsp;

  // state
  logic                started_r;
  logic [DivW-1:0]     lcm_r;
  logic                ovf_r;
  logic [OffsetW-1:0]  minoff_r, maxoff_r;
  logic [StableW-1:0]  stab_r;
  logic [SumW-1:0]     util_r;
  // latched task and working values
  logic [PeriodW-1:0]  p_r;
  logic [OffsetW-1:0]  off_r;
  logic [UtilW-1:0]    u_r;
  logic                last_r;
  logic [DivW-1:0]     ga_r, gb_r;
  logic [DivW-1:0]     q_r;
  logic [StableW-1:0]  tst_r;
  logic                ovf_chk_r;
  logic                go_r;
  // shift-and-add product
  logic [DivW-1:0]     mc_r;
  logic [PeriodW-1:0]  mp_r;
  logic [DivW-1:0]     prod_r;
  // result word
  logic [HypW-1:0]     o_hyp_r;
  logic                o_ovf_r;
  logic [OffsetW-1:0]  o_min_r, o_max_r;
  logic [StableW-1:0]  o_tst_r, o_stab_r;
  logic [SumW-1:0]     o_util_r;
  logic                o_done_r;

  logic [PeriodW-1:0]  p_in;
  logic [DivW-1:0]     p64;
  logic [SumW:0]       usum;
  logic [StableW-1:0]  ceil_st;
  logic [DivW-1:0]     kp;

  tshp_div u_div (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign p_in = (period == '0) ? PeriodW'(1) : period;
  assign p64  = DivW'(p_r);
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_FINISH;
      ST_GCD:    if (go_r || rsp.done) begin
        if (gb_r == '0) state_nxt = ST_QUOT;
      end
      ST_QUOT:   if (rsp.done) state_nxt = ST_CHECK;
      ST_CHECK:  if (rsp.done) state_nxt = ST_CEIL;
      ST_CEIL:   if (rsp.done) state_nxt = ST_OUT;
      ST_FINISH: state_nxt = ST_OUT;
      ST_OUT:    if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_IDLE && in_valid && started_r) state_nxt = ST_GCD;
  end

  // Divider requests
  always_comb begin
    req.start    = 1'b0;
    req.dividend = '0;
    req.divisor  = '1;
    case (state_r)
      ST_GCD: begin
        if ((go_r || rsp.done) && gb_r != '0) begin
          req.start    = 1'b1;
          req.dividend = go_r ? ga_r : gb_r;
          req.divisor  = go_r ? gb_r : rsp.rem;
        end else if ((go_r || rsp.done) && gb_r == '0) begin
          req.start    = 1'b1;
          req.dividend = lcm_r;
          req.divisor  = ga_r;
        end
      end
      ST_QUOT: if (rsp.done) begin
        req.start    = 1'b1;
        req.dividend = DivW'(HypMax);
        req.divisor  = p64;
      end
      ST_CHECK: if (rsp.done) begin
        req.start    = 1'b1;
        req.dividend = DivW'(maxoff_r) + p64 - DivW'(1);
        req.divisor  = p64;
      end
      default: ;
    endcase
  end

  // Rounded-up multiple of the period is the ceiling dividend less its remainder
  assign kp      = DivW'(maxoff_r) + p64 - DivW'(1) - rsp.rem;
  assign ceil_st = StableW'(kp + DivW'(off_r));
  assign usum    = {1'b0, util_r} + (SumW+1)'(u_r);

  // Multiply lcm/gcd by the period one bit a cycle while the divider runs on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mp_r <= '0;
    end else if (state_r == ST_QUOT && rsp.done) begin
      mc_r   <= rsp.quot;
      mp_r   <= p_r;
      prod_r <= '0;
    end else if (mp_r != '0) begin
      if (mp_r[0]) prod_r <= prod_r + mc_r;
      mc_r <= {mc_r[DivW-2:0], 1'b0};
      mp_r <= {1'b0, mp_r[PeriodW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      started_r <= 1'b0;
      go_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_valid) begin
          p_r    <= p_in;
          off_r  <= release_offset;
          u_r    <= utilization;
          last_r <= last_task;
          ga_r   <= lcm_r;
          gb_r   <= DivW'(p_in);
          go_r   <= 1'b1;
        end
        ST_GCD: if ((go_r || rsp.done) && gb_r != '0) begin
          if (!go_r) begin
            ga_r <= gb_r;
            gb_r <= rsp.rem;
          end
        end
        ST_QUOT: if (rsp.done) q_r <= rsp.quot;
        ST_CHECK: if (rsp.done) ovf_chk_r <= (q_r > rsp.quot);
        ST_CEIL: if (rsp.done) begin
          if (!ovf_r) begin
            if (ovf_chk_r) begin
              lcm_r <= DivW'(HypMax);
              ovf_r <= 1'b1;
            end else begin
              lcm_r <= prod_r;
            end
          end
          if (off_r < minoff_r) minoff_r <= off_r;
          if (off_r < maxoff_r) begin
            tst_r <= ceil_st;
            if (ceil_st > stab_r) stab_r <= ceil_st;
          end else begin
            maxoff_r <= off_r;
            tst_r    <= StableW'(off_r);
            if (StableW'(off_r) > stab_r) stab_r <= StableW'(off_r);
          end
          util_r <= usum[SumW] ? SumMax : usum[SumW-1:0];
        end
        ST_FINISH: begin
          started_r <= 1'b1;
          lcm_r     <= p64;
          ovf_r     <= 1'b0;
          minoff_r  <= off_r;
          maxoff_r  <= off_r;
          tst_r     <= StableW'(off_r);
          stab_r    <= StableW'(off_r);
          util_r    <= SumW'(u_r);
        end
        ST_OUT: if (out_ready && last_r) begin
          started_r <= 1'b0;
          lcm_r     <= '0;
          ovf_r     <= 1'b0;
          minoff_r  <= '0;
          maxoff_r  <= '0;
          stab_r    <= '0;
          util_r    <= '0;
        end
        default: ;
      endcase
    end
  end

  // Output word taken straight from the updated state
  always_comb begin
    o_hyp_r  = lcm_r[HypW-1:0];
    o_ovf_r  = ovf_r;
    o_min_r  = minoff_r;
    o_max_r  = maxoff_r;
    o_tst_r  = tst_r;
    o_stab_r = stab_r;
    o_util_r = util_r;
    o_done_r = last_r;
  end

  assign hyperperiod      = o_hyp_r;
  assign lcm_overflow     = o_ovf_r;
  assign min_offset       = o_min_r;
  assign max_offset       = o_max_r;
  assign task_stable_time = o_tst_r;
  assign set_stable_time  = o_stab_r;
  assign util_sum         = o_util_r;
  assign set_done         = o_done_r;
endmodule
